// ===== sv/csc_pkg.sv =====
package csc_pkg;

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int CFG_W      = 5;
	localparam int SLOT_OUT_W = 4;
	localparam int QDEPTH     = 2;

	// largest slot count the register can name
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} item_t;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage

// ===== sv/csc_front.sv =====
module csc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic signed [31:0]        lookup_key,
	input  logic signed [31:0]        write_value,
	input  logic                      q_pop,
	output csc_pkg::qhead_t           q_head
);
	import csc_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	item_t           fifo_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;
	item_t           in_item;

	assign in_stall = (count_q == CW'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && (count_q != '0);

	// classify on entry
	always_comb begin
		in_item.op    = op_t'(command);
		in_item.key   = lookup_key;
		in_item.value = write_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign q_head.valid = (count_q != '0);
	assign q_head.item  = fifo_q[rd_ptr_q];

endmodule

// ===== sv/csc_back.sv =====
module csc_back #(
	parameter int SLOTS      = 16,
	parameter int USAGE_BITS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [csc_pkg::CFG_W-1:0]      slots_cfg,
	input  csc_pkg::qhead_t                q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic signed [31:0]             read_value,
	output logic [csc_pkg::SLOT_OUT_W-1:0] slot_index
);
	import csc_pkg::*;

	// slots past what the register can name are never used
	localparam int NSLOT = (SLOTS < CFG_MAX) ? SLOTS : CFG_MAX;
	localparam int HW    = $clog2(NSLOT);
	localparam int NW    = $clog2(NSLOT + 1);
	localparam int SW    = HW + SLOT_OUT_W;
	localparam logic [USAGE_BITS-1:0] USAGE_MAX = {USAGE_BITS{1'b1}};
	localparam logic [USAGE_BITS-1:0] USAGE_ONE = USAGE_BITS'(1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t                 state_q;
	logic [KEY_W-1:0]       keys_q   [NSLOT];
	logic [VAL_W-1:0]       vals_q   [NSLOT];
	logic [USAGE_BITS-1:0]  usage_q  [NSLOT];
	logic [NSLOT-1:0]       filled_q;
	logic [HW-1:0]          hand_q;
	logic [HW-1:0]          h_q;
	logic [KEY_W-1:0]       ins_key_q;
	logic [VAL_W-1:0]       ins_val_q;

	logic                   out_valid_q;
	logic                   found_q;
	logic [VAL_W-1:0]       read_value_q;
	logic [SLOT_OUT_W-1:0]  slot_q;

	logic [CFG_W-1:0]       n_wide;
	logic [NW-1:0]          n_act;
	logic                   out_free;
	logic                   pop;
	logic                   do_search;
	logic                   do_insert;
	logic [NSLOT-1:0]       match;
	logic [NSLOT-1:0]       first;
	logic                   hit;
	logic [HW-1:0]          hit_idx;
	logic [VAL_W-1:0]       hit_val;
	logic [HW-1:0]          start_h;
	logic                   victim;
	logic [NW-1:0]          h_inc;
	logic [HW-1:0]          h_next;
	logic                   ins_done;
	logic                   load_out;
	logic                   load_found;
	logic [VAL_W-1:0]       load_val;
	logic [HW-1:0]          load_slot;
	logic [SW-1:0]          slot_wide;

	// active slot count, clamped to 1..NSLOT
	always_comb begin
		priority if (slots_cfg == '0) begin
			n_wide = CFG_W'(1);
		end else if (slots_cfg > CFG_W'(NSLOT)) begin
			n_wide = CFG_W'(NSLOT);
		end else begin
			n_wide = slots_cfg;
		end
		n_act = n_wide[NW-1:0];
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = q_head.valid && (state_q == ST_IDLE) && out_free;
	assign q_pop     = pop;
	assign do_search = pop && (q_head.item.op == OP_SEARCH);
	assign do_insert = pop && (q_head.item.op == OP_INSERT);

	// parallel key compare, lowest index wins
	always_comb begin
		for (int i = 0; i < NSLOT; i++) begin
			match[i] = filled_q[i] && (keys_q[i] == q_head.item.key) && (NW'(i) < n_act);
		end
		first   = match & (~match + 1'b1);
		hit     = (match != '0);
		hit_idx = '0;
		hit_val = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (first[i]) begin
				hit_idx = hit_idx | HW'(i);
				hit_val = hit_val | vals_q[i];
			end
		end
	end

	// sweep step; the victim waits while the output register is held
	always_comb begin
		start_h  = (NW'(hand_q) >= n_act) ? '0 : hand_q;
		victim   = !filled_q[h_q] || (usage_q[h_q] == '0);
		h_inc    = NW'(h_q) + 1'b1;
		h_next   = (h_inc == n_act) ? '0 : h_inc[HW-1:0];
		ins_done = (state_q == ST_SWEEP) && victim && out_free;
	end

	always_comb begin
		load_out   = do_search || ins_done;
		load_found = do_search && hit;
		load_val   = (do_search && hit) ? hit_val : '0;
		if (do_search) begin
			load_slot = hit ? hit_idx : '0;
		end else begin
			load_slot = h_q;
		end
		slot_wide = SW'(load_slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hand_q   <= '0;
			h_q      <= '0;
			filled_q <= '0;
			for (int i = 0; i < NSLOT; i++) begin
				usage_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_insert) begin
						h_q     <= start_h;
						state_q <= ST_SWEEP;
					end
					if (do_search && hit && (usage_q[hit_idx] != USAGE_MAX)) begin
						usage_q[hit_idx] <= usage_q[hit_idx] + 1'b1;
					end
				end
				ST_SWEEP: begin
					if (ins_done) begin
						usage_q[h_q]  <= USAGE_ONE;
						filled_q[h_q] <= 1'b1;
						hand_q        <= h_next;
						state_q       <= ST_IDLE;
					end else if (!victim) begin
						usage_q[h_q] <= usage_q[h_q] - 1'b1;
						h_q          <= h_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (do_insert) begin
			ins_key_q <= q_head.item.key;
			ins_val_q <= q_head.item.value;
		end
		if (ins_done) begin
			keys_q[h_q] <= ins_key_q;
			vals_q[h_q] <= ins_val_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q      <= load_found;
			read_value_q <= load_val;
			slot_q       <= slot_wide[SLOT_OUT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = read_value_q;
	assign slot_index = slot_q;

endmodule

// ===== sv/clock_sweep_cache.sv =====
// Path: a search result passes the front queue and then the output register; an insert
//   also passes the sweep state, k being the number of slots the hand decrements before a victim.
// Throughput: one search per cycle from the queue while no insert sweeps; an insert holds
//   the sweep engine until its victim is written, k at most (2^USAGE_BITS - 1) * slots; output stalls add to both.
// Reset (arst_n low, async): queue empty, all slots empty with zero usage, hand at 0,
//   slots_in_use back to 16. Key and value storage is not cleared.
module clock_sweep_cache #(
	parameter int SLOTS      = 16,
	parameter int USAGE_BITS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic signed [31:0]             lookup_key,
	input  logic signed [31:0]             write_value,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic signed [31:0]             read_value,
	output logic [csc_pkg::SLOT_OUT_W-1:0] slot_index,
	// slots_in_use write port
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csc_pkg::CFG_W-1:0]      cfg_data
);
	import csc_pkg::*;

	logic [CFG_W-1:0] slots_in_use_q;
	qhead_t           q_head;
	logic             q_pop;

	// Config must only be written while idle (the block does not enforce it), so it is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slots_in_use_q <= cfg_data;
		end
	end

	// Front: tags each item as insert or search and holds it in a two-entry
	// queue. It stalls only when the queue is full, so new items keep coming
	// in while the back end sweeps or a result waits downstream.
	csc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.q_pop       (q_pop),
		.q_head      (q_head)
	);

	// Back: searches all active slots with a parallel compare; inserts walk the
	// clock hand one slot per cycle, aging counts until an empty or zero-usage
	// slot turns up. Results go through a registered output stage.
	csc_back #(
		.SLOTS      (SLOTS),
		.USAGE_BITS (USAGE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slots_cfg  (slots_in_use_q),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.read_value (read_value),
		.slot_index (slot_index)
	);

endmodule

// ===== test/clock_sweep_checker.sv =====
module clock_sweep_checker #(
	parameter int SLOTS      = 16,
	parameter int USAGE_BITS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           command,
	input  logic signed [31:0]             lookup_key,
	input  logic signed [31:0]             write_value,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           found,
	input  logic signed [31:0]             read_value,
	input  logic [csc_pkg::SLOT_OUT_W-1:0] slot_index,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [csc_pkg::CFG_W-1:0]      cfg_data,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import csc_pkg::*;

	localparam int USAGE_MAX = (1 << USAGE_BITS) - 1;

	typedef struct packed {
		logic                  hit;
		logic [VAL_W-1:0]      data;
		logic [SLOT_OUT_W-1:0] slot;
	} cache_reply_t;

	logic [KEY_W-1:0]      slot_key[SLOTS];
	logic [VAL_W-1:0]      slot_value[SLOTS];
	logic [USAGE_BITS-1:0] slot_usage[SLOTS];
	logic                  slot_filled[SLOTS];
	int                    hand;
	logic [CFG_W-1:0]      slots_setting;
	cache_reply_t          replies_due[$];
	int                    mismatches;

	// 0 acts as 1, anything past SLOTS as SLOTS
	function automatic int swept_slots();
		int n;
		n = int'(slots_setting);
		if (n == 0) n = 1;
		if (n > SLOTS) n = SLOTS;
		return n;
	endfunction

	function automatic cache_reply_t predict_request(op_t op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value);
		cache_reply_t r;
		int n;
		int h;
		r = '0;
		n = swept_slots();
		if (op == OP_INSERT) begin
			h = (hand >= n) ? 0 : hand;
			for (int s = 0; s <= USAGE_MAX * SLOTS + 1; s++) begin
				if (!slot_filled[h] || slot_usage[h] == 0) break;
				slot_usage[h] = slot_usage[h] - 1'b1;
				h = (h + 1) % n;
			end
			slot_key[h]    = key;
			slot_value[h]  = value;
			slot_usage[h]  = USAGE_BITS'(1);
			slot_filled[h] = 1'b1;
			hand   = (h + 1) % n;
			r.slot = SLOT_OUT_W'(h);
		end else begin
			for (int i = 0; i < n; i++) begin
				if (slot_filled[i] && slot_key[i] == key) begin
					if (slot_usage[i] != USAGE_MAX) slot_usage[i] = slot_usage[i] + 1'b1;
					r.hit  = 1'b1;
					r.data = slot_value[i];
					r.slot = SLOT_OUT_W'(i);
					break;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cache_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_filled[i] = 1'b0;
				slot_usage[i]  = '0;
			end
			hand          = 0;
			slots_setting = CFG_RESET;
			replies_due.delete();
			mismatches    = 0;
		end else begin
			if (cfg_valid && cfg_ready) slots_setting = cfg_data;
			// results leave before new requests enter, so a result never pairs with
			// a request taken on the same edge
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("result with no request waiting: found %0d read_value %0d slot_index %0d",
						found, read_value, slot_index);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (found !== want.hit) begin
						$error("found: expected %0d, actual %0d", want.hit, found);
						mismatches++;
					end
					if (read_value !== want.data) begin
						$error("read_value: expected %0d, actual %0d", $signed(want.data),
							read_value);
						mismatches++;
					end
					if (slot_index !== want.slot) begin
						$error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due = {replies_due,
					predict_request(op_t'(command), lookup_key, write_value)};
		end
		errors  <= mismatches;
		pending <= replies_due.size();
	end

endmodule

// ===== test/tb_clock_sweep_cache.sv =====
module tb_clock_sweep_cache;
	timeunit 1ns;
	timeprecision 1ps;

	import csc_pkg::*;

	// cycles with no item moving on any channel before the run is called dead;
	// the worst honest gap is a full sweep plus a result stall burst and a send
	// gap, so this is generous
	localparam int STALL_LIMIT = 2000;
	localparam int POOL_DEPTH  = 20;
	localparam logic [31:0] CORNER_KEYS[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  command = OP_INSERT;
	logic signed [31:0]    lookup_key = '0;
	logic signed [31:0]    write_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  found;
	logic signed [31:0]    read_value;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;

	int errors;
	int pending;

	// calm turns off idling on both sides for the tail of the run
	bit          calm = 1'b0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	logic [31:0] key_pool[$];

	always #2 clk = ~clk;

	clock_sweep_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.read_value  (read_value),
		.slot_index  (slot_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	clock_sweep_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.read_value  (read_value),
		.slot_index  (slot_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending)
	);

	// result side: stall in bursts of random length, started at random
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog: any accepted item on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Present one request and hold it until taken. A random gap of idle cycles
	// may come first; without a gap valid just stays high into the next item,
	// so valid sees one assignment per edge.
	task automatic send_request(op_t op, logic [31:0] key, logic [31:0] value);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= op;
		lookup_key  <= key;
		write_value <= value;
		do @(posedge clk); while (in_stall);
	endtask

	// Inserts and searches for recently inserted keys in equal measure (hits, usage
	// bumps, sweeps that decrement), with duplicate inserts, corner keys and
	// random searches that mostly miss.
	task automatic random_request();
		int          pick;
		logic [31:0] key;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if (key_pool.size() != 0 && $urandom_range(0, 4) == 0)
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else if ($urandom_range(0, 9) == 0)
				key = CORNER_KEYS[$urandom_range(0, 3)];
			else
				key = $urandom();
			key_pool = {key_pool, key};
			if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
			send_request(OP_INSERT, key, $urandom());
		end else if (pick < 90 && key_pool.size() != 0) begin
			send_request(OP_SEARCH, key_pool[$urandom_range(0, key_pool.size() - 1)], $urandom());
		end else begin
			send_request(OP_SEARCH, $urandom(), $urandom());
		end
	endtask

	// Drop valid after the last item of a phase and wait for every result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// slots_in_use is only written with nothing in flight
	task automatic set_slots(logic [CFG_W-1:0] slots);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= slots;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		// 0 and 31 are the out-of-range ends; 4 after a full-width phase
		// usually leaves the hand past the end; 16 again brings the parked
		// slots back into the sweep
		logic [CFG_W-1:0] phase_slots[8] = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd13, 5'd16};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme keys and values, hits on each
		send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
		foreach (CORNER_KEYS[i]) send_request(OP_SEARCH, CORNER_KEYS[i], 32'hFFFF_FFFF);
		// pound one slot past the usage ceiling
		repeat (8) send_request(OP_SEARCH, 32'h8000_0000, 32'h0);
		// duplicate key: search must still land on the lower slot
		send_request(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
		send_request(OP_SEARCH, 32'h0000_0000, 32'h0);
		// clean miss
		send_request(OP_SEARCH, 32'h5555_5555, 32'hAAAA_AAAA);
		foreach (CORNER_KEYS[i]) key_pool = {key_pool, CORNER_KEYS[i]};

		// random at the reset setting, then one phase per slots_in_use value
		repeat (120) random_request();
		foreach (phase_slots[p]) begin
			set_slots(phase_slots[p]);
			if (p == $size(phase_slots) - 1) calm = 1'b1;
			repeat (125) random_request();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
